// File: rtl/wcfr_pkg.sv
// Shared types, constants and lookup tables for the word-clock frame renderer.
package wcfr_pkg;

  localparam int NUM_COLS = 12;
  localparam int COL_W    = 4;
  localparam int ROW_W    = 10;

  localparam logic [COL_W-1:0] LAST_COL = 4'(NUM_COLS - 1);

  // Display modes
  localparam logic [2:0] MODE_WORDS    = 3'd0;
  localparam logic [2:0] MODE_CLK_MIN  = 3'd1;
  localparam logic [2:0] MODE_CLK_HOUR = 3'd2;
  localparam logic [2:0] MODE_AL1_MIN  = 3'd3;
  localparam logic [2:0] MODE_AL1_HOUR = 3'd4;
  localparam logic [2:0] MODE_AL2_MIN  = 3'd5;
  localparam logic [2:0] MODE_AL2_HOUR = 3'd6;

  // One render request, packed lowest field in the lowest bits.
  typedef struct packed {
    logic       synced;
    logic       alarm_two_on;
    logic       alarm_one_on;
    logic [5:0] alarm_two_minute;
    logic [4:0] alarm_two_hour;
    logic [5:0] alarm_one_minute;
    logic [4:0] alarm_one_hour;
    logic       second_odd;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] mode;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  // A word on the matrix: one row bit over a run of columns.
  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic [COL_W-1:0] col_first;
    logic [COL_W-1:0] col_last;
  } span_t;

  localparam int W_ES      = 0;
  localparam int W_IST     = 1;
  localparam int W_UHR     = 2;
  localparam int W_FUENF   = 3;
  localparam int W_ZEHN    = 4;
  localparam int W_VIERTEL = 5;
  localparam int W_NACH    = 6;
  localparam int W_VOR1    = 7;
  localparam int W_VOR2    = 8;
  localparam int W_HALB    = 9;
  localparam int W_HOUR0   = 10;
  localparam int NUM_HOURS = 12;
  localparam int W_ALARM1  = W_HOUR0 + NUM_HOURS;
  localparam int W_ALARM2A = W_ALARM1 + 1;
  localparam int W_ALARM2B = W_ALARM1 + 2;
  localparam int W_SYNC    = W_ALARM1 + 3;
  localparam int W_COUNT   = W_SYNC + 1;

  localparam span_t SPANS [W_COUNT] = '{
    '{10'h001, 4'd0, 4'd1},  '{10'h001, 4'd4, 4'd6},  '{10'h100, 4'd9, 4'd11},
    '{10'h002, 4'd1, 4'd4},  '{10'h001, 4'd8, 4'd11}, '{10'h004, 4'd5, 4'd11},
    '{10'h008, 4'd0, 4'd3},  '{10'h002, 4'd6, 4'd8},  '{10'h008, 4'd4, 4'd6},
    '{10'h008, 4'd8, 4'd11},
    '{10'h100, 4'd1, 4'd5},  '{10'h010, 4'd8, 4'd11}, '{10'h010, 4'd6, 4'd9},
    '{10'h080, 4'd0, 4'd3},  '{10'h040, 4'd8, 4'd11}, '{10'h010, 4'd0, 4'd3},
    '{10'h020, 4'd7, 4'd11}, '{10'h020, 4'd0, 4'd5},  '{10'h080, 4'd8, 4'd11},
    '{10'h040, 4'd3, 4'd6},  '{10'h040, 4'd0, 4'd3},  '{10'h080, 4'd4, 4'd6},
    '{10'h200, 4'd1, 4'd6},  '{10'h200, 4'd1, 4'd5},  '{10'h200, 4'd7, 4'd7},
    '{10'h200, 4'd9, 4'd11}
  };

  // Minute phrase per five-minute slot, one bit per word below W_HOUR0.
  localparam logic [W_HOUR0-1:0] PHRASE [12] = '{
    10'b0000000000,
    10'b0001001000,
    10'b0001010000,
    10'b0001100000,
    10'b1010010000,
    10'b1010001000,
    10'b1000000000,
    10'b1001001000,
    10'b1001010000,
    10'b0100100000,
    10'b0010010000,
    10'b0010001000
  };

  // 4-column font, digit d at entries 4d..4d+3.
  localparam logic [7:0] GLYPHS [40] = '{
    8'hFE, 8'h82, 8'h82, 8'hFE,  8'h08, 8'h04, 8'hFE, 8'h00,
    8'hC4, 8'hA2, 8'h92, 8'h8C,  8'h82, 8'h92, 8'h92, 8'h7C,
    8'h1E, 8'h10, 8'hF8, 8'h10,  8'h9E, 8'h92, 8'h92, 8'h62,
    8'h78, 8'h94, 8'h92, 8'h60,  8'h02, 8'hF2, 8'h0A, 8'h06,
    8'hFE, 8'h92, 8'h92, 8'hFE,  8'h9E, 8'h92, 8'h92, 8'hFE
  };

  localparam logic [ROW_W-1:0] COLON_BITS = 10'h044;

  // Row bits a word contributes to one column.
  function automatic logic [ROW_W-1:0] span_column(span_t s, logic [COL_W-1:0] col);
    logic [ROW_W-1:0] res;
    res = '0;
    if ((col >= s.col_first) && (col <= s.col_last)) begin
      res = s.bits;
    end
    return res;
  endfunction

endpackage

// File: rtl/wcfr_words.sv
// Column bits of the time-in-words display for one matrix column.
module wcfr_words (
  input  wcfr_pkg::req_t                 req,
  input  logic [wcfr_pkg::COL_W-1:0]     col,
  output logic [wcfr_pkg::ROW_W-1:0]     col_bits
);
  import wcfr_pkg::*;

  logic [9:0]         slot_prod;
  logic [3:0]         slot;
  logic               min_ok;
  logic [5:0]         hour_sum;
  logic [3:0]         hour_mod;
  logic [W_COUNT-1:0] word_en;

  always_comb begin
    // minutes / 5 for 0..59: multiply by 13, keep bits 9:6
    slot_prod = 10'(req.minutes) * 10'd13;
    slot      = slot_prod[9:6];
    min_ok    = (req.minutes < 6'd60);

    hour_sum = '0;
    if (min_ok) begin
      hour_sum = 6'(req.hours) + ((req.minutes >= 6'd20) ? 6'd1 : 6'd0);
    end
    if (hour_sum >= 6'd24) begin
      hour_mod = 4'(hour_sum - 6'd24);
    end else if (hour_sum >= 6'd12) begin
      hour_mod = 4'(hour_sum - 6'd12);
    end else begin
      hour_mod = 4'(hour_sum);
    end

    word_en = '0;
    word_en[W_ES]  = 1'b1;
    word_en[W_IST] = 1'b1;
    word_en[W_UHR] = 1'b1;
    if (min_ok) begin
      word_en[W_HOUR0-1:0] = word_en[W_HOUR0-1:0] | PHRASE[slot];
    end
    for (int h = 0; h < NUM_HOURS; h++) begin
      if (hour_mod == 4'(h)) begin
        word_en[W_HOUR0 + h] = 1'b1;
      end
    end
    word_en[W_ALARM1]  = req.alarm_one_on;
    word_en[W_ALARM2A] = req.alarm_two_on;
    word_en[W_ALARM2B] = req.alarm_two_on;
    word_en[W_SYNC]    = req.synced;

    col_bits = '0;
    for (int w = 0; w < W_COUNT; w++) begin
      if (word_en[w]) begin
        col_bits = col_bits | span_column(SPANS[w], col);
      end
    end
  end

endmodule

// File: rtl/wcfr_digits.sv
// Column bits of the two-digit displays (clock and alarm, minute or hour).
module wcfr_digits (
  input  wcfr_pkg::req_t                 req,
  input  logic [wcfr_pkg::COL_W-1:0]     col,
  output logic [wcfr_pkg::ROW_W-1:0]     col_bits
);
  import wcfr_pkg::*;

  logic [5:0]       value;
  logic             is_hour;
  logic             mark_al1;
  logic             mark_al2;
  logic [3:0]       tens;
  logic [3:0]       units;
  logic [3:0]       tens_base;
  logic [3:0]       units_base;
  logic [3:0]       colon_col;
  logic [3:0]       k_tens;
  logic [3:0]       k_units;

  always_comb begin
    value    = '0;
    is_hour  = 1'b0;
    mark_al1 = 1'b0;
    mark_al2 = 1'b0;
    case (req.mode)
      MODE_CLK_MIN:  value = req.minutes;
      MODE_CLK_HOUR: begin
        value   = 6'(req.hours);
        is_hour = 1'b1;
      end
      MODE_AL1_MIN: begin
        value    = req.alarm_one_minute;
        mark_al1 = 1'b1;
      end
      MODE_AL1_HOUR: begin
        value    = 6'(req.alarm_one_hour);
        is_hour  = 1'b1;
        mark_al1 = 1'b1;
      end
      MODE_AL2_MIN: begin
        value    = req.alarm_two_minute;
        mark_al2 = 1'b1;
      end
      MODE_AL2_HOUR: begin
        value    = 6'(req.alarm_two_hour);
        is_hour  = 1'b1;
        mark_al2 = 1'b1;
      end
      default: value = '0;
    endcase

    // split into tens (0..6) and units
    if      (value >= 6'd60) tens = 4'd6;
    else if (value >= 6'd50) tens = 4'd5;
    else if (value >= 6'd40) tens = 4'd4;
    else if (value >= 6'd30) tens = 4'd3;
    else if (value >= 6'd20) tens = 4'd2;
    else if (value >= 6'd10) tens = 4'd1;
    else                     tens = 4'd0;
    units = 4'(value - 6'(tens) * 6'd10);

    tens_base  = is_hour ? 4'd0 : 4'd3;
    units_base = tens_base + 4'd5;
    colon_col  = (is_hour ? 4'd10 : 4'd0) + (req.second_odd ? 4'd0 : 4'd1);
    k_tens     = col - tens_base;
    k_units    = col - units_base;

    col_bits = '0;
    if ((col >= tens_base) && (k_tens < 4'd4)) begin
      col_bits = ROW_W'(GLYPHS[{tens[3:0], k_tens[1:0]}]);
    end else if ((col >= units_base) && (k_units < 4'd4)) begin
      col_bits = ROW_W'(GLYPHS[{units[3:0], k_units[1:0]}]);
    end else if (col == colon_col) begin
      col_bits = COLON_BITS;
    end

    if (mark_al1) begin
      col_bits = col_bits | span_column(SPANS[W_ALARM1], col);
    end
    if (mark_al2) begin
      col_bits = col_bits | span_column(SPANS[W_ALARM2A], col)
                          | span_column(SPANS[W_ALARM2B], col);
    end
  end

endmodule

// File: rtl/word_clock_frame_render.sv
// Top level of the word-clock frame renderer: request register, column sequencer, output register.
//
//  channel | dir | tdata fields (low bit up)                               | tlast
//  --------+-----+---------------------------------------------------------+--------------
//  in_     | in  | mode, hours, minutes, second_odd, alarm_one_hour,        | -
//          |     | alarm_one_minute, alarm_two_hour, alarm_two_minute,      |
//          |     | alarm_one_on, alarm_two_on, synced (40 bits)             |
//  out_    | out | column_index, column_bits, 2 zero pad bits               | last (col 11)
//
// Flow: each request yields twelve column words, one per cycle unless out_tready
// stalls them; the column counter steps the words and digits renderers over the
// columns. Each request is held in the request register, each word in the output register.
// The next request is taken in the cycle its predecessor's last column is
// loaded into the output register, so frames stream back to back.
// Reset (rst_n low, synchronous) drops any held request and output word.
// Stalls: out_tready low holds the output word and the column counter;
// in_tready falls while a request still has columns to emit.
module word_clock_frame_render (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[2:0] hours[7:3] minutes[13:8] second_odd[14]
                                  // alarm_one_hour[19:15] alarm_one_minute[25:20]
                                  // alarm_two_hour[30:26] alarm_two_minute[36:31]
                                  // alarm_one_on[37] alarm_two_on[38] synced[39]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // column_index[3:0] column_bits[13:4] zero[15:14]
  output logic        out_tlast   // last
);
  import wcfr_pkg::*;

  req_t             req_r;
  logic             req_valid_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;

  logic             out_valid_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_bits_r;
  logic             out_last_r;

  logic [ROW_W-1:0] word_bits;
  logic [ROW_W-1:0] digit_bits;
  logic [ROW_W-1:0] col_bits;

  logic             emit;
  logic             frame_done;
  logic             in_acc;

  // Column renderers: both look at the held request and current column
  wcfr_words u_words (
    .req      (req_r),
    .col      (col_r),
    .col_bits (word_bits)
  );

  wcfr_digits u_digits (
    .req      (req_r),
    .col      (col_r),
    .col_bits (digit_bits)
  );

  // Pick the display; unused mode code falls back to words
  always_comb begin
    case (req_r.mode) inside
      MODE_CLK_MIN, MODE_CLK_HOUR, MODE_AL1_MIN, MODE_AL1_HOUR,
      MODE_AL2_MIN, MODE_AL2_HOUR: col_bits = digit_bits;
      default:                     col_bits = word_bits;
    endcase
  end

  // Advance a column whenever a request is held and the output register is free or draining
  assign emit       = req_valid_r && (!out_valid_r || out_tready);
  assign frame_done = emit && (col_r == LAST_COL);
  assign in_tready  = !req_valid_r || frame_done;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    col_nxt = col_r;
    if (emit) begin
      col_nxt = frame_done ? '0 : col_r + 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      if (in_acc) begin
        req_valid_r <= 1'b1;
      end else if (frame_done) begin
        req_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold the request, load the next column word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= req_t'(in_tdata);
    end
    if (emit) begin
      out_col_r  <= col_r;
      out_bits_r <= col_bits;
      out_last_r <= (col_r == LAST_COL);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_bits_r, out_col_r};
  assign out_tlast  = out_last_r;

endmodule

// File: verif/wcfr_checker.sv
// Checker for the word-clock frame renderer: predicts each frame's column words and compares them.
`timescale 1ns / 100ps

module wcfr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding
);
  import wcfr_pkg::*;

  typedef logic [11:0][9:0] frame_t;

  typedef struct packed {
    logic [3:0] col;
    logic [9:0] rows;
    logic       last;
  } column_word_t;

  // Matrix words, one row bit over a run of columns.
  localparam int WD_ES       = 0;
  localparam int WD_IST      = 1;
  localparam int WD_UHR      = 2;
  localparam int WD_FUENF    = 3;
  localparam int WD_ZEHN     = 4;
  localparam int WD_VIERTEL  = 5;
  localparam int WD_NACH     = 6;
  localparam int WD_VOR1     = 7;
  localparam int WD_VOR2     = 8;
  localparam int WD_HALB     = 9;
  localparam int WD_HOUR0    = 10;
  localparam int WD_ALARM1   = 22;
  localparam int WD_ALARM2A  = 23;
  localparam int WD_ALARM2B  = 24;
  localparam int WD_SYNC     = 25;
  localparam int NUM_WORDS   = 26;

  localparam logic [9:0] WORD_ROW [NUM_WORDS] = '{
    10'h001, 10'h001, 10'h100, 10'h002, 10'h001, 10'h004, 10'h008, 10'h002, 10'h008, 10'h008,
    10'h100, 10'h010, 10'h010, 10'h080, 10'h040, 10'h010, 10'h020, 10'h020, 10'h080, 10'h040,
    10'h040, 10'h080, 10'h200, 10'h200, 10'h200, 10'h200
  };
  localparam int WORD_FIRST [NUM_WORDS] = '{
    0, 4, 9, 1, 8, 5, 0, 6, 4, 8,
    1, 8, 6, 0, 8, 0, 7, 0, 8, 3, 0, 4,
    1, 1, 7, 9
  };
  localparam int WORD_LAST [NUM_WORDS] = '{
    1, 6, 11, 4, 11, 11, 3, 8, 6, 11,
    5, 11, 9, 3, 11, 3, 11, 5, 11, 6, 3, 6,
    6, 5, 7, 11
  };

  // Minute phrase for each five-minute slot, one bit per word below the hours.
  localparam logic [9:0] SLOT_PHRASE [12] = '{
    10'd0,
    10'((1 << WD_FUENF) | (1 << WD_NACH)),
    10'((1 << WD_ZEHN) | (1 << WD_NACH)),
    10'((1 << WD_VIERTEL) | (1 << WD_NACH)),
    10'((1 << WD_ZEHN) | (1 << WD_VOR1) | (1 << WD_HALB)),
    10'((1 << WD_FUENF) | (1 << WD_VOR1) | (1 << WD_HALB)),
    10'((1 << WD_HALB)),
    10'((1 << WD_FUENF) | (1 << WD_NACH) | (1 << WD_HALB)),
    10'((1 << WD_ZEHN) | (1 << WD_NACH) | (1 << WD_HALB)),
    10'((1 << WD_VIERTEL) | (1 << WD_VOR2)),
    10'((1 << WD_ZEHN) | (1 << WD_VOR1)),
    10'((1 << WD_FUENF) | (1 << WD_VOR1))
  };

  localparam logic [7:0] FONT [40] = '{
    8'hFE, 8'h82, 8'h82, 8'hFE,  8'h08, 8'h04, 8'hFE, 8'h00,
    8'hC4, 8'hA2, 8'h92, 8'h8C,  8'h82, 8'h92, 8'h92, 8'h7C,
    8'h1E, 8'h10, 8'hF8, 8'h10,  8'h9E, 8'h92, 8'h92, 8'h62,
    8'h78, 8'h94, 8'h92, 8'h60,  8'h02, 8'hF2, 8'h0A, 8'h06,
    8'hFE, 8'h92, 8'h92, 8'hFE,  8'h9E, 8'h92, 8'h92, 8'hFE
  };

  localparam logic [9:0] COLON_ROWS = 10'h044;

  column_word_t expected_cols[$];
  int           mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic frame_t light_word(frame_t f, int w);
    for (int c = WORD_FIRST[w]; c <= WORD_LAST[w]; c++) begin
      f[c] = f[c] | WORD_ROW[w];
    end
    return f;
  endfunction

  function automatic frame_t place_glyph(frame_t f, int at, int digit);
    for (int k = 0; k < 4; k++) begin
      f[(at + k) % 12] = {2'b00, FONT[((digit % 10) * 4 + k) % 40]};
    end
    return f;
  endfunction

  // Two digits plus colon; hours sit left with the colon right, minutes the other way.
  function automatic frame_t draw_value(frame_t f, int value, bit is_hour, bit odd);
    int base;
    int colon;
    base  = is_hour ? 0 : 3;
    colon = is_hour ? 10 : 0;
    f = place_glyph(f, base, value / 10);
    f = place_glyph(f, base + 5, value % 10);
    f[colon + (odd ? 0 : 1)] = COLON_ROWS;
    return f;
  endfunction

  function automatic frame_t render_frame(req_t r);
    frame_t f;
    int     slot;
    int     hour_val;
    f = '0;
    case (r.mode)
      MODE_CLK_MIN:  f = draw_value(f, int'(r.minutes), 1'b0, r.second_odd);
      MODE_CLK_HOUR: f = draw_value(f, int'(r.hours), 1'b1, r.second_odd);
      MODE_AL1_MIN: begin
        f = draw_value(f, int'(r.alarm_one_minute), 1'b0, r.second_odd);
        f = light_word(f, WD_ALARM1);
      end
      MODE_AL1_HOUR: begin
        f = draw_value(f, int'(r.alarm_one_hour), 1'b1, r.second_odd);
        f = light_word(f, WD_ALARM1);
      end
      MODE_AL2_MIN: begin
        f = draw_value(f, int'(r.alarm_two_minute), 1'b0, r.second_odd);
        f = light_word(f, WD_ALARM2A);
        f = light_word(f, WD_ALARM2B);
      end
      MODE_AL2_HOUR: begin
        f = draw_value(f, int'(r.alarm_two_hour), 1'b1, r.second_odd);
        f = light_word(f, WD_ALARM2A);
        f = light_word(f, WD_ALARM2B);
      end
      default: begin
        // words, and the unused mode code falls back to them
        hour_val = 0;
        f = light_word(f, WD_ES);
        f = light_word(f, WD_IST);
        f = light_word(f, WD_UHR);
        if (r.minutes < 6'd60) begin
          slot = int'(r.minutes) / 5;
          for (int k = 0; k < WD_HOUR0; k++) begin
            if (SLOT_PHRASE[slot][k]) f = light_word(f, k);
          end
          hour_val = int'(r.hours) + ((slot >= 4) ? 1 : 0);
        end
        f = light_word(f, WD_HOUR0 + (hour_val % 12));
        if (r.alarm_one_on) f = light_word(f, WD_ALARM1);
        if (r.alarm_two_on) begin
          f = light_word(f, WD_ALARM2A);
          f = light_word(f, WD_ALARM2B);
        end
        if (r.synced) f = light_word(f, WD_SYNC);
      end
    endcase
    return f;
  endfunction

  always @(posedge clk) begin
    column_word_t exp_w;
    column_word_t got_w;
    frame_t       frame;
    if (rst_n) begin
      // compare first: a result never belongs to a request taken in the same cycle
      if (out_tvalid && out_tready) begin
        got_w = '{col: out_tdata[3:0], rows: out_tdata[13:4], last: out_tlast};
        if (expected_cols.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: column word with no request pending: col=%0d rows=%03h last=%0b",
                     $realtime, got_w.col, got_w.rows, got_w.last);
          mismatch_total++;
        end else begin
          exp_w = expected_cols.pop_front();
          if (got_w.col !== exp_w.col || got_w.rows !== exp_w.rows ||
              got_w.last !== exp_w.last) begin
            if (mismatch_total < 10)
              $display("%0t: column mismatch: exp col/rows/last=%0d/%03h/%0b got %0d/%03h/%0b",
                       $realtime, exp_w.col, exp_w.rows, exp_w.last,
                       got_w.col, got_w.rows, got_w.last);
            mismatch_total++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        frame = render_frame(req_t'(in_tdata));
        for (int c = 0; c < NUM_COLS; c++) begin
          exp_w.col  = 4'(c);
          exp_w.rows = frame[c];
          exp_w.last = (c == NUM_COLS - 1);
          expected_cols.push_back(exp_w);
        end
      end
    end
    outstanding = expected_cols.size();
  end

endmodule

// File: verif/tb_word_clock_frame_render.sv
// Testbench top for the word-clock frame renderer: request stimulus, output back-pressure, verdict.
`timescale 1ns / 100ps

module tb_word_clock_frame_render;
  import wcfr_pkg::*;

  localparam int RANDOM_REQUESTS = 420;
  localparam int QUIET_TAIL      = 60;   // requests at the end sent with no idling
  localparam int PRESSURE_AT     = 100;  // request count at which the long hold-off starts
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int outstanding;
  int requests_sent = 0;
  int total_requests = 0;
  bit quiet_phase = 1'b0;

  word_clock_frame_render uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Watch both channels, predict every column word and count mismatches.
  wcfr_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic req_t make_req(logic [2:0] mode, int hours, int minutes, bit odd,
                                    int a1_hour, int a1_min, int a2_hour, int a2_min,
                                    bit a1_on, bit a2_on, bit sync);
    req_t r;
    r.mode             = mode;
    r.hours            = 5'(hours);
    r.minutes          = 6'(minutes);
    r.second_odd       = odd;
    r.alarm_one_hour   = 5'(a1_hour);
    r.alarm_one_minute = 6'(a1_min);
    r.alarm_two_hour   = 5'(a2_hour);
    r.alarm_two_minute = 6'(a2_min);
    r.alarm_one_on     = a1_on;
    r.alarm_two_on     = a2_on;
    r.synced           = sync;
    return r;
  endfunction

  // Mostly well-formed requests weighted toward the word display;
  // one in ten is raw bits so out-of-range values and the spare mode show up.
  function automatic req_t random_request();
    req_t        r;
    logic [63:0] raw;
    int          pick;
    raw = {$urandom, $urandom};
    r = raw[39:0];
    if ($urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, 11);
      r.mode             = (pick > 6) ? MODE_WORDS : 3'(pick);
      r.hours            = 5'($urandom_range(0, 23));
      r.minutes          = 6'($urandom_range(0, 59));
      r.alarm_one_hour   = 5'($urandom_range(0, 23));
      r.alarm_one_minute = 6'($urandom_range(0, 59));
      r.alarm_two_hour   = 5'($urandom_range(0, 23));
      r.alarm_two_minute = 6'($urandom_range(0, 59));
    end
    return r;
  endfunction

  // Offer one request and hold it until taken. in_tready is sampled at the
  // falling edge so the decision never races the block's own update.
  task automatic send_request(input req_t r);
    logic ready_seen;
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    requests_sent++;
    quiet_phase = (requests_sent >= total_requests - QUIET_TAIL);
    // drop valid for a random burst now and then
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Request stimulus and verdict.
  initial begin
    req_t directed_reqs[$];

    // zeros and all-ones extremes
    directed_reqs.push_back(make_req(MODE_WORDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(req_t'({40{1'b1}}));
    // words: hour advances from minute 20, 23 wraps to twelve, marks lit
    directed_reqs.push_back(make_req(MODE_WORDS, 11, 20, 1, 0, 0, 0, 0, 1, 0, 0));
    directed_reqs.push_back(make_req(MODE_WORDS, 23, 59, 1, 23, 59, 23, 59, 1, 1, 1));
    directed_reqs.push_back(make_req(MODE_WORDS, 23, 19, 0, 0, 0, 0, 0, 0, 1, 0));
    directed_reqs.push_back(make_req(MODE_WORDS, 12, 45, 0, 0, 0, 0, 0, 0, 0, 1));
    // words: minutes past 59 light no phrase, hours past 23 wrap
    directed_reqs.push_back(make_req(MODE_WORDS, 5, 60, 0, 0, 0, 0, 0, 1, 1, 1));
    directed_reqs.push_back(make_req(MODE_WORDS, 31, 30, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_WORDS, 24, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    // spare mode code renders words
    directed_reqs.push_back(make_req(3'd7, 7, 35, 1, 0, 0, 0, 0, 1, 0, 1));
    // digit modes at the ends of their ranges, both colon phases
    directed_reqs.push_back(make_req(MODE_CLK_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_CLK_MIN, 0, 59, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_CLK_MIN, 0, 63, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_CLK_HOUR, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_CLK_HOUR, 23, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_CLK_HOUR, 31, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL1_MIN, 0, 0, 0, 0, 59, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL1_MIN, 0, 0, 1, 0, 63, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL1_HOUR, 0, 0, 0, 23, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL1_HOUR, 0, 0, 1, 31, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL2_MIN, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL2_MIN, 0, 0, 0, 0, 0, 0, 63, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL2_HOUR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(MODE_AL2_HOUR, 0, 0, 1, 0, 0, 31, 0, 0, 0, 0));

    total_requests = directed_reqs.size() + RANDOM_REQUESTS;

    // hold reset low, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reqs[i]) send_request(directed_reqs[i]);
    for (int i = 0; i < RANDOM_REQUESTS; i++) send_request(random_request());
    in_tvalid <= 1'b0;

    // drain: wait for every predicted column word, then let the pipe settle
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Output back-pressure: one long hold-off so the block fills and stalls its
  // input, random stall bursts otherwise, and a steady ready in the tail.
  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    @(posedge clk);
    forever begin
      if (!pressure_done && requests_sent >= PRESSURE_AT) begin
        out_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
